/* hw/rtl/multi_channel_byte_pipe_assert.svh */
// ----------------------------------------------------------------------------
// multi_channel_byte_pipe_assert.svh
// assertion macros used by the checker of the byte pipe bank
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_BYTE_PIPE_ASSERT_SVH
`define MULTI_CHANNEL_BYTE_PIPE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MCBP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mcbp: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define MCBP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mcbp: assertion failed");

`endif

/* hw/rtl/mcbp_pkg.sv */
// ----------------------------------------------------------------------------
// mcbp_pkg
// sizes, field widths and codes of the multi-channel byte pipe bank
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcbp_pkg;

	// bank geometry
	localparam int NUM_PIPES  = 8;
	localparam int PIPE_DEPTH = 256;
	localparam int READ_BURST = 16;

	// derived sizes
	localparam int PIPE_W      = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int PTR_W       = $clog2(PIPE_DEPTH);
	localparam int FILL_W      = $clog2(PIPE_DEPTH + 1);
	localparam int BURST_W     = $clog2(READ_BURST + 1);
	localparam int STORE_DEPTH = NUM_PIPES * PIPE_DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// request and result field widths
	localparam int OP_W     = 2;
	localparam int ID_W     = 3;
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 5;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 16;

	localparam logic [COUNT_W-1:0] RUN_MAX = {COUNT_W{1'b1}};

	// operation codes
	localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ   = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;
	localparam logic [OP_W-1:0] OP_CLOSE  = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_BADID  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOFREE = 3'd4;

endpackage

/* hw/rtl/mcbp_chan_if.sv */
// ----------------------------------------------------------------------------
// mcbp_chan_if
// request and result channels of the byte pipe bank, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mcbp_req_if;
	import mcbp_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [ID_W-1:0]     pipe_id;
	logic [BYTE_W-1:0]   data_byte;
	logic [LEN_W-1:0]    read_len;
	logic                end_of_write;

	modport source (
		output valid, operation, pipe_id, data_byte, read_len, end_of_write,
		input  ready
	);
	modport sink (
		input  valid, operation, pipe_id, data_byte, read_len, end_of_write,
		output ready
	);
endinterface

interface mcbp_res_if;
	import mcbp_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     new_pipe;
	logic [BYTE_W-1:0]   read_byte;
	logic [COUNT_W-1:0]  run_count;
	logic                final_res;
	logic                wake_readers;
	logic                wake_writers;

	modport source (
		output valid, status, new_pipe, read_byte, run_count, final_res,
		       wake_readers, wake_writers,
		input  ready
	);
	modport sink (
		input  valid, status, new_pipe, read_byte, run_count, final_res,
		       wake_readers, wake_writers,
		output ready
	);
endinterface

/* hw/rtl/multi_channel_byte_pipe.sv */
// ----------------------------------------------------------------------------
// multi_channel_byte_pipe
// create, write, close and reads with no burst give one result, in the cycle after the request
// read burst of n bytes: each byte passes the burst sequencer, the byte store read register
// and the output register; then one byte per cycle while the result channel is ready
// throughput: one request per cycle while the output is free; none while a burst runs
// reset: pipe table, pointers, fill levels and write run clear at once; byte store is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_channel_byte_pipe (
	input logic        clk,
	input logic        arst_n,
	mcbp_req_if.sink   req,
	mcbp_res_if.source res
);
	import mcbp_pkg::*;

	localparam int SUM_W = ((PTR_W > BURST_W) ? PTR_W : BURST_W) + 1;

	localparam logic [0:0] FSM_IDLE = 1'b0;
	localparam logic [0:0] FSM_READ = 1'b1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     new_pipe;
		logic [BYTE_W-1:0]   read_byte;
		logic [COUNT_W-1:0]  run_count;
		logic                final_res;
		logic                wake_readers;
		logic                wake_writers;
	} res_t;

	// flat store address of a pipe slot
	function automatic logic [ADDR_W-1:0] store_addr(input logic [PIPE_W-1:0] p,
	                                                 input logic [PTR_W-1:0] ptr);
		store_addr = ADDR_W'(p) * ADDR_W'(PIPE_DEPTH) + ADDR_W'(ptr);
	endfunction

	// ring pointer plus one
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(PIPE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// ring pointer plus a burst length, which never exceeds the depth
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
	                                             input logic [BURST_W-1:0] n);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(p) + SUM_W'(n);
		if (sum >= SUM_W'(PIPE_DEPTH)) begin
			sum = sum - SUM_W'(PIPE_DEPTH);
		end
		ptr_add = PTR_W'(sum);
	endfunction

	// per-pipe control state
	logic [NUM_PIPES-1:0] alloc_q;
	logic [PTR_W-1:0]     rd_ptr_q [NUM_PIPES];
	logic [PTR_W-1:0]     wr_ptr_q [NUM_PIPES];
	logic [FILL_W-1:0]    fill_q   [NUM_PIPES];
	logic [COUNT_W-1:0]   write_run_q;

	// burst sequencer
	logic [0:0]           state_q;
	logic [PIPE_W-1:0]    brst_pipe_q;
	logic [PTR_W-1:0]     brst_ptr_q;
	logic [BURST_W-1:0]   brst_left_q;
	logic [BURST_W-1:0]   brst_len_q;
	logic                 pend_s1;
	logic                 last_s1;

	// output register
	logic                 out_valid_q;
	res_t                 out_q;

	// decode
	logic [PIPE_W-1:0]    pidx;
	logic                 id_ok;
	logic                 pipe_valid;
	logic [FILL_W-1:0]    cur_fill;
	logic                 cur_full;
	logic                 free_found;
	logic [PIPE_W-1:0]    free_idx;
	logic [BURST_W-1:0]   brst_n;
	logic [COUNT_W-1:0]   run_inc;
	logic                 out_free;
	logic                 accept;
	logic                 do_write;
	logic                 start_burst;
	res_t                 single_res;
	res_t                 burst_res;
	logic                 load;
	logic                 issue;
	logic [BYTE_W-1:0]    ram_rd_data;

	assign pidx       = PIPE_W'(req.pipe_id);
	assign id_ok      = int'(req.pipe_id) < NUM_PIPES;
	assign pipe_valid = id_ok && alloc_q[pidx];
	assign cur_fill   = fill_q[pidx];
	assign cur_full   = cur_fill == FILL_W'(PIPE_DEPTH);
	assign run_inc    = (write_run_q == RUN_MAX) ? write_run_q : write_run_q + 1'b1;

	// lowest free pipe
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_PIPES - 1; i >= 0; i--) begin
			if (!alloc_q[i]) begin
				free_found = 1'b1;
				free_idx   = PIPE_W'(i);
			end
		end
	end

	// burst length: request, capped by burst limit and fill level
	always_comb begin
		logic [COUNT_W-1:0] len_c;
		logic [COUNT_W-1:0] fill_c;
		len_c = COUNT_W'(req.read_len);
		if (len_c > COUNT_W'(READ_BURST)) begin
			len_c = COUNT_W'(READ_BURST);
		end
		fill_c = COUNT_W'(cur_fill);
		brst_n = BURST_W'((len_c < fill_c) ? len_c : fill_c);
	end

	// handshake
	assign out_free  = !out_valid_q || res.ready;
	assign req.ready = (state_q == FSM_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	// single-result answers
	always_comb begin
		single_res           = '0;
		single_res.final_res = 1'b1;
		start_burst          = 1'b0;
		case (req.operation)
			OP_CREATE: begin
				if (free_found) begin
					single_res.status   = STAT_OK;
					single_res.new_pipe = ID_W'(free_idx);
				end else begin
					single_res.status = STAT_NOFREE;
				end
			end
			OP_WRITE: begin
				if (!pipe_valid) begin
					single_res.status    = STAT_BADID;
					single_res.run_count = write_run_q;
				end else if (cur_full) begin
					single_res.status    = STAT_FULL;
					single_res.run_count = write_run_q;
				end else begin
					single_res.status       = STAT_OK;
					single_res.run_count    = run_inc;
					single_res.wake_readers = 1'b1;
				end
			end
			OP_CLOSE: begin
				if (!pipe_valid) begin
					single_res.status = STAT_BADID;
				end else begin
					single_res.status       = STAT_OK;
					single_res.wake_readers = 1'b1;
					single_res.wake_writers = 1'b1;
				end
			end
			OP_READ: begin
				if (!pipe_valid) begin
					single_res.status = STAT_BADID;
				end else if (cur_fill == '0) begin
					single_res.status = STAT_EMPTY;
				end else if (brst_n == '0) begin
					single_res.status       = STAT_OK;
					single_res.wake_writers = 1'b1;
				end else begin
					start_burst = 1'b1;
				end
			end
			default: begin
				single_res.status = STAT_BADID;
			end
		endcase
	end

	assign do_write = accept && (req.operation == OP_WRITE) && pipe_valid && !cur_full;

	// burst engine: issue a store read while bytes are left and no byte is pending or it can move on
	assign load  = pend_s1 && out_free;
	assign issue = (state_q == FSM_READ) && (brst_left_q != '0) && (!pend_s1 || load);

	always_comb begin
		burst_res              = '0;
		burst_res.status       = STAT_OK;
		burst_res.read_byte    = ram_rd_data;
		burst_res.run_count    = COUNT_W'(brst_len_q);
		burst_res.final_res    = last_s1;
		burst_res.wake_writers = last_s1;
	end

	// byte store
	mcbp_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (do_write),
		.wr_addr (store_addr(pidx, wr_ptr_q[pidx])),
		.wr_data (req.data_byte),
		.rd_en   (issue),
		.rd_addr (store_addr(brst_pipe_q, brst_ptr_q)),
		.rd_data (ram_rd_data)
	);

	// pipe table and write run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q     <= '0;
			write_run_q <= '0;
			for (int i = 0; i < NUM_PIPES; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				fill_q[i]   <= '0;
			end
		end else if (accept) begin
			case (req.operation)
				OP_CREATE: begin
					if (free_found) begin
						alloc_q[free_idx]  <= 1'b1;
						rd_ptr_q[free_idx] <= '0;
						wr_ptr_q[free_idx] <= '0;
						fill_q[free_idx]   <= '0;
					end
				end
				OP_WRITE: begin
					if (!pipe_valid) begin
						write_run_q <= '0;
					end else if (!cur_full) begin
						wr_ptr_q[pidx] <= ptr_next(wr_ptr_q[pidx]);
						fill_q[pidx]   <= cur_fill + 1'b1;
						write_run_q    <= req.end_of_write ? '0 : run_inc;
					end
				end
				OP_CLOSE: begin
					if (pipe_valid) begin
						alloc_q[pidx] <= 1'b0;
					end
				end
				OP_READ: begin
					if (start_burst) begin
						rd_ptr_q[pidx] <= ptr_add(rd_ptr_q[pidx], brst_n);
						fill_q[pidx]   <= cur_fill - FILL_W'(brst_n);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// burst sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			brst_left_q <= '0;
			pend_s1     <= 1'b0;
		end else begin
			pend_s1 <= issue || (pend_s1 && !load);
			if (accept && start_burst) begin
				state_q     <= FSM_READ;
				brst_left_q <= brst_n;
			end else begin
				if (issue) begin
					brst_left_q <= brst_left_q - 1'b1;
				end
				if (load && last_s1) begin
					state_q <= FSM_IDLE;
				end
			end
		end
	end

	// burst payload registers
	always_ff @(posedge clk) begin
		if (accept && start_burst) begin
			brst_pipe_q <= pidx;
			brst_ptr_q  <= rd_ptr_q[pidx];
			brst_len_q  <= brst_n;
		end else if (issue) begin
			brst_ptr_q <= ptr_next(brst_ptr_q);
		end
		if (issue) begin
			last_s1 <= brst_left_q == BURST_W'(1);
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load || (accept && !start_burst)) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= burst_res;
		end else if (accept && !start_burst) begin
			out_q <= single_res;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.status       = out_q.status;
	assign res.new_pipe     = out_q.new_pipe;
	assign res.read_byte    = out_q.read_byte;
	assign res.run_count    = out_q.run_count;
	assign res.final_res    = out_q.final_res;
	assign res.wake_readers = out_q.wake_readers;
	assign res.wake_writers = out_q.wake_writers;

endmodule

/* hw/rtl/mcbp_ram.sv */
// ----------------------------------------------------------------------------
// mcbp_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/mcbp_checker.sv */
// ----------------------------------------------------------------------------
// mcbp_checker
// port-level checks on the result channel of the byte pipe bank
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "multi_channel_byte_pipe_assert.svh"

module mcbp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [mcbp_pkg::STATUS_W-1:0] res_status,
	input logic [mcbp_pkg::ID_W-1:0]     res_new_pipe,
	input logic [mcbp_pkg::BYTE_W-1:0]   res_read_byte,
	input logic [mcbp_pkg::COUNT_W-1:0]  res_run_count,
	input logic                          res_final_res,
	input logic                          res_wake_readers,
	input logic                          res_wake_writers
);
	import mcbp_pkg::*;

	logic [STATUS_W+ID_W+BYTE_W+COUNT_W+2:0] res_payload;

	assign res_payload = {res_status, res_new_pipe, res_read_byte, res_run_count,
	                      res_final_res, res_wake_readers, res_wake_writers};

	// a stalled result holds its value
	`MCBP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_payload))

	// any failure is a single, final result
	`MCBP_ASSERT_IMPL(a_fail_final, res_valid && (res_status != STAT_OK), res_final_res)

	// wakeups only come with success
	`MCBP_ASSERT_IMPL(a_wake_ok, res_valid && (res_wake_readers || res_wake_writers), res_status == STAT_OK)

	// a popped byte belongs to a burst of legal length
	`MCBP_ASSERT_IMPL(a_byte_burst, res_valid && (res_read_byte != '0), (res_run_count != '0) && (res_run_count <= COUNT_W'(READ_BURST)))

endmodule

bind multi_channel_byte_pipe mcbp_checker u_mcbp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_status       (res.status),
	.res_new_pipe     (res.new_pipe),
	.res_read_byte    (res.read_byte),
	.res_run_count    (res.run_count),
	.res_final_res    (res.final_res),
	.res_wake_readers (res.wake_readers),
	.res_wake_writers (res.wake_writers)
);
